[rtl/midi_note_on_tracker_assert.svh]
// Assertion macros for the note-on tracker.
// Used by the top level; expects a clock named clk and a reset named rst in scope.
`ifndef MIDI_NOTE_ON_TRACKER_ASSERT_SVH
`define MIDI_NOTE_ON_TRACKER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MNT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define MNT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/mnt_pkg.sv]
// Shared types and constants for the note-on tracker.
// No dependencies; used by mnt_parse, mnt_table and midi_note_on_tracker.
`timescale 1ns / 1ps
`default_nettype none

package mnt_pkg;

  localparam logic [7:0] STATUS_NOTE_ON = 8'h90;

  typedef enum logic [1:0] {
    KIND_OK          = 2'd0,
    KIND_OFF_NO_ON   = 2'd1,
    KIND_ON_WHILE_ON = 2'd2,
    KIND_FORMAT      = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PH_STATUS = 2'd0,
    PH_NOTE   = 2'd1,
    PH_VEL    = 2'd2
  } phase_t;

  // parser -> table
  typedef struct packed {
    logic       rd_en;     // note byte accepted: fetch its counter
    logic [7:0] rd_note;
    logic       upd_en;    // velocity byte accepted: update the note
    logic [7:0] upd_note;
    logic       vel_nz;
  } tbl_req_t;

  // parser -> result stage
  typedef struct packed {
    logic fmt_err;
    logic done;
  } prs_ev_t;

endpackage

`default_nettype wire

[rtl/mnt_parse.sv]
// Byte-wise note-on message assembler (status, note, velocity).
// Depends on mnt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mnt_parse (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             adv,
  input  wire logic [7:0]       rx_byte,
  output mnt_pkg::tbl_req_t     req,
  output mnt_pkg::prs_ev_t      ev,
  output logic      [7:0]       held_note
);

  mnt_pkg::phase_t phase, phase_next;

  always_comb begin
    phase_next = phase;
    if (adv) begin
      case (phase)
        mnt_pkg::PH_NOTE: phase_next = mnt_pkg::PH_VEL;
        mnt_pkg::PH_VEL:  phase_next = mnt_pkg::PH_STATUS;
        default: begin
          // unused code behaves as awaiting status
          phase_next = (rx_byte == mnt_pkg::STATUS_NOTE_ON) ? mnt_pkg::PH_NOTE
                                                            : mnt_pkg::PH_STATUS;
        end
      endcase
    end
  end

  always_comb begin
    req          = '0;
    ev           = '0;
    req.rd_note  = rx_byte;
    req.upd_note = held_note;
    req.vel_nz   = (rx_byte != 8'd0);
    case (phase)
      mnt_pkg::PH_NOTE: req.rd_en = adv;
      mnt_pkg::PH_VEL: begin
        req.upd_en = adv;
        ev.done    = adv;
      end
      default: ev.fmt_err = adv && (rx_byte != mnt_pkg::STATUS_NOTE_ON);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= mnt_pkg::PH_STATUS;
      held_note <= 8'd0;
    end else begin
      phase <= phase_next;
      if (adv && phase == mnt_pkg::PH_NOTE) begin
        held_note <= rx_byte;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/mnt_table.sv]
// Per-note on bit and saturating on counter, kept together in one RAM word.
// Read at the note beat, written at the velocity beat; valid bits blank entries after reset.
// Depends on mnt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mnt_table #(
  parameter int NOTE_SLOTS = 256,
  parameter int COUNT_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire mnt_pkg::tbl_req_t     req,
  output logic                       was_on,
  output logic [COUNT_BITS-1:0]      cnt_new
);

  localparam int AW = $clog2(NOTE_SLOTS);
  localparam logic [8:0] SLOTS_W = 9'(NOTE_SLOTS);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  logic [NOTE_SLOTS-1:0] cnt_vld;                // entry written since reset
  logic [COUNT_BITS:0]   cnt_mem [NOTE_SLOTS];   // {on bit, counter}
  logic [COUNT_BITS:0]   rd_q;
  logic                  vld_q;
  logic [COUNT_BITS-1:0] cnt_old;
  logic [AW-1:0]         idx_rd;
  logic [AW-1:0]         idx_up;
  logic                  tracked;
  logic                  wr_en;

  assign idx_rd  = req.rd_note[AW-1:0];
  assign idx_up  = req.upd_note[AW-1:0];
  assign tracked = ({1'b0, req.upd_note} < SLOTS_W);

  always_comb begin
    was_on  = tracked && vld_q && rd_q[COUNT_BITS];
    cnt_old = vld_q ? rd_q[COUNT_BITS-1:0] : '0;
    if (!tracked) begin
      cnt_new = '0;
    end else if (req.vel_nz && cnt_old != CNT_MAX) begin
      cnt_new = cnt_old + COUNT_BITS'(1);
    end else begin
      cnt_new = cnt_old;
    end
  end

  assign wr_en = req.upd_en && tracked;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_vld <= '0;
    end else if (wr_en) begin
      cnt_vld[idx_up] <= 1'b1;
    end
  end

  // read data held from the note beat until the velocity beat
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_q  <= cnt_mem[idx_rd];
      vld_q <= cnt_vld[idx_rd];
    end
    if (wr_en) begin
      cnt_mem[idx_up] <= {req.vel_nz, cnt_new};
    end
  end

endmodule

`default_nettype wire

[rtl/midi_note_on_tracker.sv]
// Note-on tracker top level: byte stream in, one result beat per message or bad byte.
// Channels: s_* carries one received byte per beat; m_* carries the result beat.
// Each message is status 0x90, note, velocity. A byte other than 0x90 where a
// status is expected gives a format-error beat. The velocity beat updates the
// note's on bit and saturating on counter and produces the message result.
// A result is registered and is on m_* in the cycle after the beat that causes it.
// Throughput: one byte per cycle while m_* is not stalled; the note RAM is read at the note beat
// and written at the velocity beat, so its single read port sets no limit.
// s_tready is high whenever the result register is empty or being taken, so
// a stalled receiver holds the result and s_tready stays low until it is taken.
// Reset (rst, synchronous) returns to awaiting status and clears the entry
// valid bits, so every note reads as off with a zero count.
// Depends on mnt_pkg, mnt_parse, mnt_table and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

module midi_note_on_tracker #(
  parameter int NOTE_SLOTS = 256,
  parameter int COUNT_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // rx_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // status_byte, note_number, velocity, on_count
  output logic [1:0]       m_tuser    // event_kind
);

  mnt_pkg::tbl_req_t     req;
  mnt_pkg::prs_ev_t      prs_ev;
  logic [7:0]            held_note;
  logic                  was_on;
  logic [COUNT_BITS-1:0] cnt_new;
  logic                  adv;
  logic                  load;
  logic [31:0]           cnt_ext;
  logic [15:0]           cnt_rep;
  logic [1:0]            kind;
  logic [39:0]           data_next;

  assign s_tready = !m_tvalid || m_tready;
  assign adv      = s_tvalid && s_tready;

  mnt_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .rx_byte   (s_tdata),
    .req       (req),
    .ev        (prs_ev),
    .held_note (held_note)
  );

  mnt_table #(
    .NOTE_SLOTS (NOTE_SLOTS),
    .COUNT_BITS (COUNT_BITS)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .was_on  (was_on),
    .cnt_new (cnt_new)
  );

  always_comb begin
    cnt_ext = 32'(cnt_new);
    cnt_rep = (cnt_ext > 32'h0000_FFFF) ? 16'hFFFF : cnt_ext[15:0];
    if (prs_ev.fmt_err) begin
      kind      = mnt_pkg::KIND_FORMAT;
      data_next = {16'd0, 8'd0, 8'd0, s_tdata};
    end else begin
      if (s_tdata == 8'd0) begin
        kind = was_on ? mnt_pkg::KIND_OK : mnt_pkg::KIND_OFF_NO_ON;
      end else begin
        kind = was_on ? mnt_pkg::KIND_ON_WHILE_ON : mnt_pkg::KIND_OK;
      end
      data_next = {cnt_rep, s_tdata, held_note, mnt_pkg::STATUS_NOTE_ON};
    end
  end

  assign load = prs_ev.fmt_err || prs_ev.done;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= data_next;
      m_tuser <= kind;
    end
  end

`include "midi_note_on_tracker_assert.svh"

  `MNT_ASSERT_NEXT(a_fmt_result, prs_ev.fmt_err, m_tvalid && m_tuser == mnt_pkg::KIND_FORMAT, "format error beat lost")
  `MNT_ASSERT_NEXT(a_msg_status, prs_ev.done, m_tvalid && m_tdata[7:0] == mnt_pkg::STATUS_NOTE_ON, "message result missing status")
  `MNT_ASSERT_NOW(a_stall_blocks, m_tvalid && !m_tready, !s_tready && !load, "input taken while result stalled")

endmodule

`default_nettype wire

[sim/tb_top.sv]
// Testbench for midi_note_on_tracker: byte stream in, checked result beats out.
// A scoreboard class predicts every result beat; needs rtl/mnt_pkg.sv and the block's RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int NOTE_SLOTS = 256;
  localparam int COUNT_BITS = 16;
  localparam int STALL_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // rx_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;           // status_byte, note_number, velocity, on_count
  logic [1:0]  m_tuser;           // event_kind

  midi_note_on_tracker #(
    .NOTE_SLOTS(NOTE_SLOTS),
    .COUNT_BITS(COUNT_BITS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  typedef struct {
    mnt_pkg::kind_t kind;
    logic [7:0]     status;
    logic [7:0]     note;
    logic [7:0]     vel;
    logic [15:0]    cnt;
  } note_event_t;

  class note_tracker_sb;
    mnt_pkg::phase_t        ph;
    logic [7:0]             held;
    bit                     on_bits[NOTE_SLOTS];
    logic [COUNT_BITS-1:0]  on_counts[NOTE_SLOTS];
    note_event_t            event_q[$];
    int                     errors;

    function new();
      ph = mnt_pkg::PH_STATUS;
      held = 8'h00;
      errors = 0;
      foreach (on_bits[i]) begin
        on_bits[i] = 1'b0;
        on_counts[i] = '0;
      end
    endfunction

    // advance the message assembler by one accepted byte
    function void note_byte(logic [7:0] b);
      note_event_t           r;
      int                    idx;
      bit                    tracked;
      bit                    was_on;
      logic [COUNT_BITS-1:0] c;
      case (ph)
        mnt_pkg::PH_NOTE: begin
          held = b;
          ph = mnt_pkg::PH_VEL;
        end
        mnt_pkg::PH_VEL: begin
          ph = mnt_pkg::PH_STATUS;
          idx = held;
          tracked = idx < NOTE_SLOTS;
          was_on = tracked && on_bits[idx];
          c = '0;
          r.kind = mnt_pkg::KIND_OK;
          r.status = mnt_pkg::STATUS_NOTE_ON;
          r.note = held;
          r.vel = b;
          if (b == 8'h00) begin
            if (!was_on) r.kind = mnt_pkg::KIND_OFF_NO_ON;
            if (tracked) begin
              on_bits[idx] = 1'b0;
              c = on_counts[idx];
            end
          end else begin
            if (was_on) r.kind = mnt_pkg::KIND_ON_WHILE_ON;
            if (tracked) begin
              on_bits[idx] = 1'b1;
              if (on_counts[idx] != '1) on_counts[idx] = on_counts[idx] + 1'b1;
              c = on_counts[idx];
            end
          end
          r.cnt = (c > 65535) ? 16'hFFFF : 16'(c);
          event_q.push_back(r);
        end
        default: begin
          // also covers the unused phase code
          ph = mnt_pkg::PH_STATUS;
          if (b == mnt_pkg::STATUS_NOTE_ON) begin
            ph = mnt_pkg::PH_NOTE;
          end else begin
            r.kind = mnt_pkg::KIND_FORMAT;
            r.status = b;
            r.note = 8'h00;
            r.vel = 8'h00;
            r.cnt = 16'h0000;
            event_q.push_back(r);
          end
        end
      endcase
    endfunction

    function void cmp(string name, longint unsigned exp_v, longint unsigned act_v);
      if (exp_v != act_v) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_beat(logic [1:0] kind, logic [39:0] data);
      note_event_t r;
      if (event_q.size() == 0) begin
        $error("result beat with nothing expected: kind %0d data 0x%0h", kind, data);
        errors++;
      end else begin
        r = event_q.pop_front();
        cmp("event_kind", r.kind, kind);
        cmp("status_byte", r.status, data[7:0]);
        cmp("note_number", r.note, data[15:8]);
        cmp("velocity", r.vel, data[23:16]);
        cmp("on_count", r.cnt, data[39:24]);
      end
    endfunction

    function int waiting();
      return event_q.size();
    endfunction
  endclass

  note_tracker_sb sb = new();

  bit quiet = 1'b0;
  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int snk_hold = 0;
  int stall_cycles = 0;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // result receiver: random stall bursts
  always @(negedge clk) begin
    if (snk_hold > 0) begin
      snk_hold--;
      m_tready = 1'b0;
    end else if (!quiet && $urandom_range(99) < snk_idle_pct) begin
      m_tready = 1'b0;
      snk_hold = $urandom_range(1, 18) - 1;
    end else begin
      m_tready = 1'b1;
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_beat(m_tuser, m_tdata);
      if (s_tvalid && s_tready) sb.note_byte(s_tdata);
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  // entered and left at a falling edge
  task automatic send_byte(logic [7:0] b);
    if (!quiet && $urandom_range(99) < src_idle_pct) begin
      s_tvalid = 1'b0;
      s_tdata = 8'($urandom);
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = b;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic send_msg(logic [7:0] note, logic [7:0] vel);
    send_byte(mnt_pkg::STATUS_NOTE_ON);
    send_byte(note);
    send_byte(vel);
  endtask

  // mostly whole messages, some stray bytes and cut-off messages
  task automatic random_bytes(int n);
    int sent;
    int pick;
    logic [7:0] note;
    logic [7:0] vel;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        note = $urandom_range(1) ? 8'(8'h3C + $urandom_range(0, 7)) : 8'($urandom);
        vel = ($urandom_range(2) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
        send_msg(note, vel);
        sent += 3;
      end else if (pick < 90) begin
        send_byte(8'($urandom));
        sent += 1;
      end else begin
        send_byte(mnt_pkg::STATUS_NOTE_ON);
        send_byte(8'($urandom));
        sent += 2;
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: bad status bytes, off without on, on while on, status as data
    src_idle_pct = 20;
    snk_idle_pct = 20;
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h8F);
    send_byte(8'h91);
    send_msg(8'h00, 8'h00);
    send_msg(8'hFF, 8'h7F);
    send_msg(8'hFF, 8'hFF);
    send_msg(8'hFF, 8'h00);
    send_msg(mnt_pkg::STATUS_NOTE_ON, mnt_pkg::STATUS_NOTE_ON);
    send_msg(mnt_pkg::STATUS_NOTE_ON, 8'h00);

    src_idle_pct = 15;
    snk_idle_pct = 15;
    random_bytes(560);
    src_idle_pct = 0;
    snk_idle_pct = 25;
    random_bytes(560);
    src_idle_pct = 25;
    snk_idle_pct = 0;
    random_bytes(300);

    quiet = 1'b1;
    random_bytes(350);
    random_bytes(60);

    s_tvalid = 1'b0;
    while (sb.waiting() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.waiting() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
